/* hdl/acm_pkg.sv */
// shared types and constants for the adc clipping monitor
// no dependencies; used by every module of the block
`default_nettype none

package acm_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CHAN_W    = 4;
  localparam int BITS_W    = 5;
  localparam int COUNT_W   = 21;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int NUM_FRAC  = 4;
  localparam int SEL_W     = 2;

  localparam logic [COUNT_W-1:0] MAX_LEN    = COUNT_W'(1048576);
  localparam logic [BITS_W-1:0]  BITS_RESET = BITS_W'(8);

  // fraction slots, in result order
  localparam logic [SEL_W-1:0] SEL_TOP     = 2'd0;
  localparam logic [SEL_W-1:0] SEL_BOT     = 2'd1;
  localparam logic [SEL_W-1:0] SEL_TOP_RUN = 2'd2;
  localparam logic [SEL_W-1:0] SEL_BOT_RUN = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   channel;
    logic                last_sample;
  } in_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  result_channel;
    logic [COUNT_W-1:0] top_clip_count;
    logic [COUNT_W-1:0] bottom_clip_count;
    logic [COUNT_W-1:0] top_run_count;
    logic [COUNT_W-1:0] bottom_run_count;
    logic [FRAC_W-1:0]  top_fraction;
    logic [FRAC_W-1:0]  bottom_fraction;
    logic [FRAC_W-1:0]  top_run_fraction;
    logic [FRAC_W-1:0]  bottom_run_fraction;
  } out_beat_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic             count_en;
    logic             snap_load;
    logic             div_start;
    logic             div_step;
    logic             frac_store;
    logic [SEL_W-1:0] frac_sel;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

/* hdl/acm_datapath.sv */
// datapath: record counters, end-of-record snapshot, shared restoring divider
// depends on acm_pkg; driven by acm_controller commands
`default_nettype none

module acm_datapath (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_wr_en,
  input  wire [acm_pkg::BITS_W-1:0]    cfg_wr_data,
  input  wire acm_pkg::in_beat_t       in_beat,
  input  wire acm_pkg::ctrl_cmd_t      cmd,
  output acm_pkg::out_beat_t           out_beat
);

  localparam int CW = acm_pkg::COUNT_W;
  localparam int RW = acm_pkg::COUNT_W + 1;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [1:0] inc);
    logic [CW:0] s;
    s = {1'b0, a} + (CW+1)'(inc);
    return (s > {1'b0, acm_pkg::MAX_LEN}) ? acm_pkg::MAX_LEN : s[CW-1:0];
  endfunction

  logic [acm_pkg::BITS_W-1:0] digitizer_bits;

  logic [CW-1:0] record_length, top_count, bottom_count, top_run_total, bottom_run_total;
  logic          prev_top, prev_bot, top_done, bot_done, have_previous;

  logic [CW-1:0] record_length_next, top_count_next, bottom_count_next;
  logic [CW-1:0] top_run_total_next, bottom_run_total_next;
  logic          is_top, is_bot, top_pair, bot_pair;
  logic [acm_pkg::SAMPLE_W:0] full_scale;

  // snapshot of the finished record
  logic [acm_pkg::CHAN_W-1:0] snap_channel;
  logic [CW-1:0] snap_length, snap_top, snap_bot, snap_top_run, snap_bot_run;

  // divider
  logic [CW-1:0] den, div_num, div_den;
  logic [RW-1:0] rem, rem_dbl;
  logic [acm_pkg::FRAC_W-1:0] quot;
  logic          step_bit, start_bit;
  logic [acm_pkg::FRAC_W-1:0] frac [acm_pkg::NUM_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      digitizer_bits <= acm_pkg::BITS_RESET;
    end else if (cfg_wr_en) begin
      digitizer_bits <= cfg_wr_data;
    end
  end

  // classification; resolutions above 16 bits never clip at the top
  always_comb begin
    full_scale = ((acm_pkg::SAMPLE_W+1)'(1) << digitizer_bits[4:0]) - (acm_pkg::SAMPLE_W+1)'(1);
    is_top     = (digitizer_bits <= acm_pkg::BITS_W'(acm_pkg::SAMPLE_W)) &&
                 ({1'b0, in_beat.sample} >= full_scale);
    is_bot     = (in_beat.sample == '0);
    top_pair   = is_top && have_previous && prev_top;
    bot_pair   = is_bot && have_previous && prev_bot;

    record_length_next    = sat_add(record_length, 2'd1);
    top_count_next        = is_top ? sat_add(top_count, 2'd1) : top_count;
    bottom_count_next     = is_bot ? sat_add(bottom_count, 2'd1) : bottom_count;
    // first pair credits both samples, later ones only the newcomer
    top_run_total_next    = top_pair ? sat_add(top_run_total, top_done ? 2'd1 : 2'd2)
                                     : top_run_total;
    bottom_run_total_next = bot_pair ? sat_add(bottom_run_total, bot_done ? 2'd1 : 2'd2)
                                     : bottom_run_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_length    <= '0;
      top_count        <= '0;
      bottom_count     <= '0;
      top_run_total    <= '0;
      bottom_run_total <= '0;
      prev_top         <= 1'b0;
      prev_bot         <= 1'b0;
      top_done         <= 1'b0;
      bot_done         <= 1'b0;
      have_previous    <= 1'b0;
    end else if (cmd.count_en) begin
      if (in_beat.last_sample) begin
        record_length    <= '0;
        top_count        <= '0;
        bottom_count     <= '0;
        top_run_total    <= '0;
        bottom_run_total <= '0;
        prev_top         <= 1'b0;
        prev_bot         <= 1'b0;
        top_done         <= 1'b0;
        bot_done         <= 1'b0;
        have_previous    <= 1'b0;
      end else begin
        record_length    <= record_length_next;
        top_count        <= top_count_next;
        bottom_count     <= bottom_count_next;
        top_run_total    <= top_run_total_next;
        bottom_run_total <= bottom_run_total_next;
        prev_top         <= is_top;
        prev_bot         <= is_bot;
        top_done         <= top_pair;
        bot_done         <= bot_pair;
        have_previous    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap_load) begin
      snap_channel <= in_beat.channel;
      snap_length  <= record_length_next;
      snap_top     <= top_count_next;
      snap_bot     <= bottom_count_next;
      snap_top_run <= top_run_total_next;
      snap_bot_run <= bottom_run_total_next;
    end
  end

  // operand select; numerator never exceeds its denominator
  always_comb begin
    case (cmd.frac_sel)
      acm_pkg::SEL_TOP:     begin div_num = snap_top;     div_den = snap_length; end
      acm_pkg::SEL_BOT:     begin div_num = snap_bot;     div_den = snap_length; end
      acm_pkg::SEL_TOP_RUN: begin div_num = snap_top_run; div_den = snap_top;    end
      acm_pkg::SEL_BOT_RUN: begin div_num = snap_bot_run; div_den = snap_bot;    end
      default:              begin div_num = snap_top;     div_den = snap_length; end
    endcase
    start_bit = (div_num >= div_den);
    rem_dbl   = {rem[RW-2:0], 1'b0};
    step_bit  = (rem_dbl >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      den  <= div_den;
      rem  <= {1'b0, div_num} - (start_bit ? {1'b0, div_den} : '0);
      quot <= acm_pkg::FRAC_W'(start_bit);
    end else if (cmd.div_step) begin
      rem  <= rem_dbl - (step_bit ? {1'b0, den} : '0);
      quot <= {quot[acm_pkg::FRAC_W-2:0], step_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frac_store) begin
      // empty denominator gives a zero fraction
      frac[cmd.frac_sel] <= (den == '0) ? '0 : quot;
    end
  end

  assign out_beat.result_channel      = snap_channel;
  assign out_beat.top_clip_count      = snap_top;
  assign out_beat.bottom_clip_count   = snap_bot;
  assign out_beat.top_run_count       = snap_top_run;
  assign out_beat.bottom_run_count    = snap_bot_run;
  assign out_beat.top_fraction        = frac[acm_pkg::SEL_TOP];
  assign out_beat.bottom_fraction     = frac[acm_pkg::SEL_BOT];
  assign out_beat.top_run_fraction    = frac[acm_pkg::SEL_TOP_RUN];
  assign out_beat.bottom_run_fraction = frac[acm_pkg::SEL_BOT_RUN];

endmodule

`default_nettype wire

/* hdl/acm_controller.sv */
// controller: handshakes, division sequencing and result hold
// depends on acm_pkg; commands acm_datapath
`default_nettype none

module acm_controller (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  wire                 in_last,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  output acm_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_COUNT = 3'b001,
    ST_DIV   = 3'b010,
    ST_HOLD  = 3'b100
  } state_t;

  localparam logic [4:0] STEP_LAST = 5'd16;
  localparam logic [4:0] STORE_CYC = 5'd17;

  state_t                    state, state_next;
  logic [4:0]                cyc, cyc_next;
  logic [acm_pkg::SEL_W-1:0] sel, sel_next;
  logic                      accept;

  // non-last samples keep counting while the previous record finishes
  assign in_ready  = (state == ST_COUNT) || !in_last;
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == ST_HOLD);

  always_comb begin
    state_next     = state;
    cyc_next       = cyc;
    sel_next       = sel;
    cmd.count_en   = accept;
    cmd.snap_load  = 1'b0;
    cmd.div_start  = 1'b0;
    cmd.div_step   = 1'b0;
    cmd.frac_store = 1'b0;
    cmd.frac_sel   = sel;
    case (state)
      ST_COUNT: begin
        if (accept && in_last) begin
          cmd.snap_load = 1'b1;
          state_next    = ST_DIV;
          cyc_next      = '0;
          sel_next      = acm_pkg::SEL_TOP;
        end
      end
      ST_DIV: begin
        cyc_next = cyc + 5'd1;
        if (cyc == '0) begin
          cmd.div_start = 1'b1;
        end else if (cyc <= STEP_LAST) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.frac_store = 1'b1;
          cyc_next       = '0;
          sel_next       = sel + acm_pkg::SEL_W'(1);
          if (sel == acm_pkg::SEL_BOT_RUN) begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_ready) begin
          state_next = ST_COUNT;
        end
      end
      default: begin
        state_next = ST_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COUNT;
      cyc   <= '0;
      sel   <= '0;
    end else begin
      state <= state_next;
      cyc   <= (cyc_next > STORE_CYC) ? '0 : cyc_next;
      sel   <= sel_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/adc_clipping_monitor_top.sv */
// top level of the adc clipping monitor
// depends on acm_pkg, acm_controller and acm_datapath
// throughput: one sample beat per cycle inside a record; a last-sample beat
//   is taken only once the previous record's result beat has been taken
// the result beat turns valid after the last-sample beat once the four fractions
//   are computed in turn on the shared one-bit-per-cycle divider
// reset (rst, synchronous): record counters cleared, no result pending,
//   digitizer_bits back to 8
`default_nettype none

module adc_clipping_monitor_top (
  input  wire                         clk,
  input  wire                         rst,
  // configuration: converter resolution
  input  wire                         cfg_wr_en,
  input  wire [acm_pkg::BITS_W-1:0]   cfg_wr_data,
  // sample channel
  input  wire                         sample_valid,
  output logic                        sample_ready,
  input  wire acm_pkg::in_beat_t      sample_beat,
  // result channel
  output logic                        result_valid,
  input  wire                         result_ready,
  output acm_pkg::out_beat_t          result_beat
);

  // command bundle from sequencer to datapath
  acm_pkg::ctrl_cmd_t cmd;

  // sequencer: accepts beats, runs the four divisions, holds the result
  acm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_valid),
    .in_last   (sample_beat.last_sample),
    .in_ready  (sample_ready),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .cmd       (cmd)
  );

  // counters, record snapshot, divider and result registers
  acm_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_beat     (sample_beat),
    .cmd         (cmd),
    .out_beat    (result_beat)
  );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for adc_clipping_monitor_top: random sample records
// under several resolutions, results checked against an in-bench statistics model
// depends on acm_pkg and the block's rtl

module tb_top;
  import acm_pkg::*;

  // far above the longest legal quiet stretch (the four divisions plus stalls)
  localparam int IDLE_LIMIT   = 4000;
  // drain for longer than the result latency after the last-sample beat
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASES       = 10;
  localparam int PHASE_BEATS  = 63;

  typedef enum int {PICK_TOP, PICK_NEAR, PICK_BOT, PICK_ANY} pick_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              cfg_wr_en    = 1'b0;
  logic [BITS_W-1:0] cfg_wr_data  = '0;
  logic              sample_valid = 1'b0;
  logic              sample_ready;
  in_beat_t          sample_beat  = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  out_beat_t         result_beat;

  adc_clipping_monitor_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_beat  (sample_beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_beat  (result_beat)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // stimulus and scoreboard bookkeeping
  in_beat_t    beats_pending[$];
  out_beat_t   stats_due[$];
  int unsigned beats_queued = 0;
  int unsigned beats_taken  = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  bit          gapless      = 1'b0;
  logic        in_taken     = 1'b0;
  int          send_gap     = 0;
  int          stall_left   = 0;

  // model of the block: resolution register and per-record tallies
  logic [BITS_W-1:0] model_bits = BITS_RESET;
  int unsigned rec_len = 0;
  int unsigned top_cnt = 0;
  int unsigned bot_cnt = 0;
  int unsigned top_run = 0;
  int unsigned bot_run = 0;
  bit          prev_top  = 1'b0;
  bit          prev_bot  = 1'b0;
  bit          top_done  = 1'b0;
  bit          bot_done  = 1'b0;
  bit          seen_prev = 1'b0;

  function automatic int unsigned sat_add(int unsigned a, int unsigned inc);
    return (a + inc > MAX_LEN) ? int'(MAX_LEN) : a + inc;
  endfunction

  // num * 2^16 / den, truncated, zero for an empty denominator
  function automatic logic [FRAC_W-1:0] q16_ratio(int unsigned num, int unsigned den);
    longint unsigned q;
    if (den == 0) return '0;
    q = (longint'(num) << FRAC_BITS) / den;
    return q[FRAC_W-1:0];
  endfunction

  // folds one sample into the record tallies; returns 1 with the statistics
  // when the sample closes the record
  function automatic bit tally_sample(in_beat_t b, output out_beat_t stats);
    longint unsigned full_scale;
    bit is_top, is_bot, nxt_top_done, nxt_bot_done;
    full_scale   = (64'd1 << model_bits) - 64'd1;
    is_top       = b.sample >= full_scale;
    is_bot       = b.sample == '0;
    nxt_top_done = 1'b0;
    nxt_bot_done = 1'b0;
    stats        = '0;
    rec_len = sat_add(rec_len, 1);
    if (is_top) begin
      top_cnt = sat_add(top_cnt, 1);
      // a new pair also counts the earlier sample, unless it already counted
      if (seen_prev && prev_top) begin
        top_run      = sat_add(top_run, top_done ? 1 : 2);
        nxt_top_done = 1'b1;
      end
    end
    if (is_bot) begin
      bot_cnt = sat_add(bot_cnt, 1);
      if (seen_prev && prev_bot) begin
        bot_run      = sat_add(bot_run, bot_done ? 1 : 2);
        nxt_bot_done = 1'b1;
      end
    end
    prev_top  = is_top;
    prev_bot  = is_bot;
    top_done  = nxt_top_done;
    bot_done  = nxt_bot_done;
    seen_prev = 1'b1;
    if (!b.last_sample) return 1'b0;
    stats.result_channel      = b.channel;
    stats.top_clip_count      = COUNT_W'(top_cnt);
    stats.bottom_clip_count   = COUNT_W'(bot_cnt);
    stats.top_run_count       = COUNT_W'(top_run);
    stats.bottom_run_count    = COUNT_W'(bot_run);
    stats.top_fraction        = q16_ratio(top_cnt, rec_len);
    stats.bottom_fraction     = q16_ratio(bot_cnt, rec_len);
    stats.top_run_fraction    = q16_ratio(top_run, top_cnt);
    stats.bottom_run_fraction = q16_ratio(bot_run, bot_cnt);
    rec_len   = 0;
    top_cnt   = 0;
    bot_cnt   = 0;
    top_run   = 0;
    bot_run   = 0;
    prev_top  = 1'b0;
    prev_bot  = 1'b0;
    top_done  = 1'b0;
    bot_done  = 1'b0;
    seen_prev = 1'b0;
    return 1'b1;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    if (gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sample value of the wanted class for the given resolution
  function automatic logic [SAMPLE_W-1:0] pick_sample(pick_t kind, int unsigned bits);
    longint unsigned fs;
    fs = (64'd1 << bits) - 64'd1;
    case (kind)
      PICK_TOP: begin
        // above 16 bits nothing clips; still hit the top code
        if (fs > 65535) return '1;
        if ($urandom_range(0, 1) == 1) return SAMPLE_W'(fs);
        return SAMPLE_W'($urandom_range(65535, 32'(fs)));
      end
      PICK_NEAR: begin
        if (fs == 0 || fs > 65536) return SAMPLE_W'($urandom_range(0, 65535));
        return SAMPLE_W'(fs - 1);
      end
      PICK_BOT: return '0;
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_beat(logic [SAMPLE_W-1:0] smp, logic [CHAN_W-1:0] chan, bit last);
    in_beat_t b;
    b.sample      = smp;
    b.channel     = chan;
    b.last_sample = last;
    beats_pending.push_back(b);
    beats_queued++;
  endtask

  // one record built from short runs of like samples so that clip pairs are
  // common; about one record in seven is plain noise
  task automatic add_record(int unsigned bits);
    int unsigned len, run, sel;
    int i;
    bit noisy;
    pick_t kind;
    logic [CHAN_W-1:0] chan;
    len   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 64);
    chan  = CHAN_W'($urandom_range(0, 15));
    noisy = $urandom_range(0, 6) == 0;
    i = 0;
    while (i < len) begin
      sel  = $urandom_range(0, 99);
      kind = noisy ? PICK_ANY : sel < 30 ? PICK_TOP : sel < 55 ? PICK_BOT :
             sel < 65 ? PICK_NEAR : PICK_ANY;
      run  = $urandom_range(1, 4);
      repeat (run) begin
        if (i < len) begin
          // the block reports the channel of the closing sample only
          if ($urandom_range(0, 9) == 0) chan = CHAN_W'($urandom_range(0, 15));
          add_beat(pick_sample(kind, bits), chan, i == len - 1);
          i++;
        end
      end
    end
  endtask

  // everything sent and answered, then let the back stage run dry
  task automatic settle();
    while (beats_taken != beats_queued || stats_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_bits(logic [BITS_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [BITS_W-1:0] bits;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed records at the reset resolution (full scale 255)
    add_beat(16'd0, 4'd0, 1'b1);        // lone zero sample: no pair possible
    add_beat(16'd255, 4'd15, 1'b1);     // lone sample exactly at full scale
    // mixed record with a channel switch before the closing sample
    add_beat(16'hFFFF, 4'd3, 1'b0);
    add_beat(16'd255, 4'd3, 1'b0);
    add_beat(16'd254, 4'd3, 1'b0);      // one below full scale
    add_beat(16'd0, 4'd3, 1'b0);
    add_beat(16'd0, 4'd3, 1'b0);
    add_beat(16'd0, 4'd9, 1'b0);
    add_beat(16'd1, 4'd9, 1'b0);
    add_beat(16'd0, 4'd9, 1'b0);
    add_beat(16'd256, 4'd9, 1'b0);
    add_beat(16'hFFFF, 4'd12, 1'b1);
    add_beat(16'd0, 4'd5, 1'b0);        // two zeros: both count as a pair
    add_beat(16'd0, 4'd5, 1'b1);
    // every sample clips at the top, none at the bottom: the bottom run fraction has a zero denominator
    add_beat(16'h8000, 4'd10, 1'b0);
    add_beat(16'h5555, 4'd10, 1'b0);
    add_beat(16'hAAAA, 4'd10, 1'b0);
    add_beat(16'h7FFF, 4'd6, 1'b1);
    settle();

    // resolution extremes first, including the out-of-range codes, then random
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: bits = 5'd1;
        1: bits = 5'd16;
        2: bits = 5'd0;
        3: bits = 5'd31;
        4: bits = 5'd17;
        default: bits = ($urandom_range(0, 1) == 1) ? BITS_W'($urandom_range(1, 16)) :
                                                      BITS_W'($urandom_range(0, 31));
      endcase
      write_bits(bits);
      gapless = $urandom_range(0, 3) == 0;
      begin : fill
        int unsigned target;
        target = beats_queued + PHASE_BEATS;
        while (beats_queued < target) add_record(32'(bits));
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // sample driver: offers one beat at a time, holds it until taken
  always @(negedge clk) begin : driver
    if (!rst) begin
      if (!sample_valid || in_taken) begin
        if (send_gap > 0) begin
          sample_valid <= 1'b0;
          send_gap = send_gap - 1;
        end else if (beats_pending.size() != 0) begin
          sample_beat  <= beats_pending.pop_front();
          sample_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin : receiver
    if (!rst) begin
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        result_ready <= 1'b1;
        stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // model update on every accepted sample beat, compare on every result beat
  always @(posedge clk) begin : monitor
    out_beat_t stats;
    out_beat_t due;
    if (rst) begin
      in_taken <= 1'b0;
      model_bits = BITS_RESET;
    end else begin
      in_taken <= sample_valid && sample_ready;
      if (cfg_wr_en) model_bits = cfg_wr_data;
      if (sample_valid && sample_ready) begin
        beats_taken++;
        if (tally_sample(sample_beat, stats)) stats_due.push_back(stats);
      end
      if (result_valid && result_ready) begin
        if (stats_due.size() == 0) begin
          $error("result beat with no closed record pending");
          mismatches++;
        end else begin
          due = stats_due.pop_front();
          check_field("result_channel", 32'(due.result_channel),
                      32'(result_beat.result_channel));
          check_field("top_clip_count", 32'(due.top_clip_count),
                      32'(result_beat.top_clip_count));
          check_field("bottom_clip_count", 32'(due.bottom_clip_count),
                      32'(result_beat.bottom_clip_count));
          check_field("top_run_count", 32'(due.top_run_count),
                      32'(result_beat.top_run_count));
          check_field("bottom_run_count", 32'(due.bottom_run_count),
                      32'(result_beat.bottom_run_count));
          check_field("top_fraction", 32'(due.top_fraction),
                      32'(result_beat.top_fraction));
          check_field("bottom_fraction", 32'(due.bottom_fraction),
                      32'(result_beat.bottom_fraction));
          check_field("top_run_fraction", 32'(due.top_run_fraction),
                      32'(result_beat.top_run_fraction));
          check_field("bottom_run_fraction", 32'(due.bottom_run_fraction),
                      32'(result_beat.bottom_run_fraction));
        end
      end
    end
  end

  // ends a hung run: too many cycles without any beat or register write
  always @(posedge clk) begin : watchdog
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) ||
        cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles < IDLE_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
